// File: hw/rtl/ycbcr_quad_to_rgb565_core_defines.svh
// Assertion macros used by the checker file of the quad color converter.
`ifndef YCBCR_QUAD_TO_RGB565_CORE_DEFINES_SVH
`define YCBCR_QUAD_TO_RGB565_CORE_DEFINES_SVH

// Overlapping implication, checked on the rising clock edge outside reset.
`define YQR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define YQR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/yqr_pkg.sv
// Types and fixed-point constants of the quad color converter.
`default_nettype none

package yqr_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned PixelW   = 16;
  localparam int unsigned ProdW    = 27;
  localparam int unsigned OffsW    = 10;
  localparam int unsigned SumW     = 11;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumPix   = 4;

  localparam logic signed [18:0] LumaGain = 19'sd76309;
  localparam logic signed [18:0] CrToR    = 19'sd104597;
  localparam logic signed [18:0] CbToG    = 19'sd25674;
  localparam logic signed [18:0] CrToG    = 19'sd53278;
  localparam logic signed [18:0] CbToB    = 19'sd132201;

  localparam logic signed [8:0]  ChromaBias = 9'sd128;
  localparam logic signed [9:0]  LumaBlack  = 10'sd16;
  localparam logic signed [SumW-1:0] ChanMax = 11'sd248;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [PixelW-1:0]  pixel_t;

  typedef struct packed {
    logic signed [OffsW-1:0] r;
    logic signed [OffsW-1:0] g;
    logic signed [OffsW-1:0] b;
  } chroma_offs_t;

endpackage

`default_nettype wire

// File: hw/rtl/yqr_chroma.sv
// Chroma offsets for R, G and B shared by the four pixels of a quad.
`default_nettype none

module yqr_chroma (
  input  var yqr_pkg::sample_t      chroma_blue_i,
  input  var yqr_pkg::sample_t      chroma_red_i,
  output var yqr_pkg::chroma_offs_t offs_o
);

  logic signed [8:0]                cb;
  logic signed [8:0]                cr;
  logic signed [yqr_pkg::ProdW-1:0] prod_r;
  logic signed [yqr_pkg::ProdW-1:0] prod_g;
  logic signed [yqr_pkg::ProdW-1:0] prod_b;

  assign cb = $signed({1'b0, chroma_blue_i}) - yqr_pkg::ChromaBias;
  assign cr = $signed({1'b0, chroma_red_i}) - yqr_pkg::ChromaBias;

  assign prod_r = yqr_pkg::ProdW'(cr) * yqr_pkg::ProdW'(yqr_pkg::CrToR);
  assign prod_g = yqr_pkg::ProdW'(cb) * yqr_pkg::ProdW'(yqr_pkg::CbToG)
                + yqr_pkg::ProdW'(cr) * yqr_pkg::ProdW'(yqr_pkg::CrToG);
  assign prod_b = yqr_pkg::ProdW'(cb) * yqr_pkg::ProdW'(yqr_pkg::CbToB);

  // Taking the bits above the fraction is a floor toward minus infinity.
  assign offs_o.r = prod_r[yqr_pkg::FracW +: yqr_pkg::OffsW];
  assign offs_o.g = prod_g[yqr_pkg::FracW +: yqr_pkg::OffsW];
  assign offs_o.b = prod_b[yqr_pkg::FracW +: yqr_pkg::OffsW];

endmodule

`default_nettype wire

// File: hw/rtl/yqr_pixel.sv
// Luma expansion, channel saturation and RGB565 packing for one pixel.
`default_nettype none

module yqr_pixel (
  input  var yqr_pkg::sample_t      luma_i,
  input  var yqr_pkg::chroma_offs_t offs_i,
  output var yqr_pkg::pixel_t       pixel_o
);

  logic signed [9:0]                 luma_m;
  logic signed [yqr_pkg::ProdW-1:0]  prod_y;
  logic signed [yqr_pkg::OffsW-1:0]  yv;
  logic signed [yqr_pkg::SumW-1:0]   sum_r;
  logic signed [yqr_pkg::SumW-1:0]   sum_g;
  logic signed [yqr_pkg::SumW-1:0]   sum_b;
  logic [7:0]                        chan_r;
  logic [7:0]                        chan_g;
  logic [7:0]                        chan_b;

  function automatic logic [7:0] sat_chan(input logic signed [yqr_pkg::SumW-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > yqr_pkg::ChanMax) begin
      res = yqr_pkg::ChanMax[7:0];
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign luma_m = $signed({2'b00, luma_i}) - yqr_pkg::LumaBlack;
  assign prod_y = yqr_pkg::ProdW'(luma_m) * yqr_pkg::ProdW'(yqr_pkg::LumaGain);
  assign yv     = prod_y[yqr_pkg::FracW +: yqr_pkg::OffsW];

  assign sum_r = yqr_pkg::SumW'(yv) + yqr_pkg::SumW'(offs_i.r);
  assign sum_g = yqr_pkg::SumW'(yv) - yqr_pkg::SumW'(offs_i.g);
  assign sum_b = yqr_pkg::SumW'(yv) + yqr_pkg::SumW'(offs_i.b);

  assign chan_r = sat_chan(sum_r);
  assign chan_g = sat_chan(sum_g);
  assign chan_b = sat_chan(sum_b);

  assign pixel_o = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};

endmodule

`default_nettype wire

// File: hw/rtl/ycbcr_quad_to_rgb565_core.sv
// Top level of the 4:2:0 quad to RGB565 color converter.
// The block takes one 2x2 luma quad with its shared Cb and Cr samples per transfer and
// returns four BT.601 studio-range RGB565 pixels, R in bits 15:11. It accepts one quad
// every clock cycle while the input is not stalled. A quad is held in the input register,
// then converted into the result register, from which it can transfer out: the conversion
// sits between the input register and the result register.
// While the output is stalled the result register holds and the input register can still
// take one more quad, so the input stalls only when both registers are full.
`default_nettype none

module ycbcr_quad_to_rgb565_core (
  input  var logic                   clk_i,
  input  var logic                   rst_ni,
  input  var logic                   in_valid_i,
  output var logic                   in_stall_o,
  input  var yqr_pkg::sample_t       luma_top_left_i,
  input  var yqr_pkg::sample_t       luma_top_right_i,
  input  var yqr_pkg::sample_t       luma_bottom_left_i,
  input  var yqr_pkg::sample_t       luma_bottom_right_i,
  input  var yqr_pkg::sample_t       chroma_blue_i,
  input  var yqr_pkg::sample_t       chroma_red_i,
  output var logic                   out_valid_o,
  input  var logic                   out_stall_i,
  output var yqr_pkg::pixel_t        pixel_top_left_o,
  output var yqr_pkg::pixel_t        pixel_top_right_o,
  output var yqr_pkg::pixel_t        pixel_bottom_left_o,
  output var yqr_pkg::pixel_t        pixel_bottom_right_o
);

  logic                  in_vld_q;
  logic                  in_vld_d;
  logic                  out_vld_q;
  logic                  out_vld_d;
  logic                  in_ready;
  logic                  out_ready;
  logic                  in_load;
  logic                  out_load;

  yqr_pkg::sample_t      luma_q [yqr_pkg::NumPix];
  yqr_pkg::sample_t      cb_q;
  yqr_pkg::sample_t      cr_q;
  yqr_pkg::chroma_offs_t offs;
  yqr_pkg::pixel_t       pix    [yqr_pkg::NumPix];
  yqr_pkg::pixel_t       pix_q  [yqr_pkg::NumPix];

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign in_ready   = !in_vld_q || out_ready;
  assign in_load    = in_valid_i && in_ready;
  assign out_load   = out_ready && in_vld_q;
  assign in_stall_o = !in_ready;

  assign in_vld_d  = in_ready ? in_valid_i : in_vld_q;
  assign out_vld_d = out_ready ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      luma_q[0] <= luma_top_left_i;
      luma_q[1] <= luma_top_right_i;
      luma_q[2] <= luma_bottom_left_i;
      luma_q[3] <= luma_bottom_right_i;
      cb_q      <= chroma_blue_i;
      cr_q      <= chroma_red_i;
    end
  end

  yqr_chroma u_chroma (
    .chroma_blue_i (cb_q),
    .chroma_red_i  (cr_q),
    .offs_o        (offs)
  );

  for (genvar i = 0; i < yqr_pkg::NumPix; i++) begin : g_pix
    yqr_pixel u_pixel (
      .luma_i  (luma_q[i]),
      .offs_i  (offs),
      .pixel_o (pix[i])
    );

    always_ff @(posedge clk_i) begin
      if (out_load) begin
        pix_q[i] <= pix[i];
      end
    end
  end

  assign out_valid_o          = out_vld_q;
  assign pixel_top_left_o     = pix_q[0];
  assign pixel_top_right_o    = pix_q[1];
  assign pixel_bottom_left_o  = pix_q[2];
  assign pixel_bottom_right_o = pix_q[3];

endmodule

`default_nettype wire

// File: hw/rtl/yqr_core_chk.sv
// Port-level checker of the quad color converter and its bind to the top level.
`default_nettype none

`include "ycbcr_quad_to_rgb565_core_defines.svh"

module yqr_core_chk (
  input var logic            clk_i,
  input var logic            rst_ni,
  input var logic            in_valid_i,
  input var logic            in_stall_o,
  input var logic            out_valid_o,
  input var logic            out_stall_i,
  input var yqr_pkg::pixel_t pixel_top_left_o,
  input var yqr_pkg::pixel_t pixel_top_right_o,
  input var yqr_pkg::pixel_t pixel_bottom_left_o,
  input var yqr_pkg::pixel_t pixel_bottom_right_o
);

  logic in_xfer;
  logic out_hold;
  logic [4*yqr_pkg::PixelW-1:0] pix_all;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign pix_all  = {pixel_top_left_o, pixel_top_right_o, pixel_bottom_left_o,
                     pixel_bottom_right_o};

  `YQR_ASSERT_IMP(a_stall_only_when_full, in_stall_o, out_hold, "input stalled with room left")
  `YQR_ASSERT_IMP(a_result_has_source, $rose(out_valid_o), $past(in_xfer, 2), "orphan result")
  `YQR_ASSERT_NXT(a_out_valid_holds, out_hold, out_valid_o, "stalled result was dropped")
  `YQR_ASSERT_NXT(a_out_data_holds, out_hold, $stable(pix_all), "stalled result changed")

endmodule

bind ycbcr_quad_to_rgb565_core yqr_core_chk u_chk (.*);

`default_nettype wire
